>>> hdl/rpl_pkg.sv
`default_nettype none

package rpl_pkg;

  // Default number of pages held in the recency list and in the prefetch queue
  localparam int LIST_DEPTH_DEF = 32;

  // Address and page geometry (4 KiB pages)
  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

  // Width of the reported counts
  localparam int COUNT_W = 6;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_GATHER = 2'd1,
    FUNC_ISSUE  = 2'd2
  } func_e;

endpackage

`default_nettype wire

>>> hdl/recency_page_prefetch_list_top.sv
`default_nettype none
// Issue items, unused codes and gathers of an empty list go straight to the report state.
// Record items compare the listed pages (one list read per cycle), shift entries down over a
// removed slot, append the page and report; gather items move the listed pages into the
// queue, settle and report. One item at a time: busy_o is high until the strobe, and the next
// item is taken at the edge that ends it; the result shows for one cycle and cannot be stalled.
// Asynchronous active-low reset empties the list and the queue; the memories are not cleared.

module recency_page_prefetch_list_top #(
  parameter int LIST_DEPTH = rpl_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [rpl_pkg::ADDR_W-1:0]    addr_i,
  input  wire logic                          accepted_i,
  output logic                               valid_o,
  output logic      [rpl_pkg::ADDR_W-1:0]    pf_addr_o,
  output logic                               issued_o,
  output logic      [rpl_pkg::COUNT_W-1:0]   queue_count_o,
  output logic      [rpl_pkg::COUNT_W-1:0]   recent_count_o
);

  import rpl_pkg::*;

  localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int CW1 = CW + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_SHIFT  = 7'b0000100,
    ST_APPEND = 7'b0001000,
    ST_GATHER = 7'b0010000,
    ST_SETTLE = 7'b0100000,
    ST_REPORT = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic             pop_q, pop_d;
  logic [CW-1:0]    rfill_q, rfill_d;
  logic [IW-1:0]    qhead_q, qhead_d;
  logic [CW-1:0]    qfill_q, qfill_d;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] pf_q, pf_d;
  logic              issued_q, issued_d;
  logic [COUNT_W-1:0] qcnt_q, qcnt_d;
  logic [COUNT_W-1:0] rcnt_q, rcnt_d;

  // Memory ports
  logic              r_we;
  logic [IW-1:0]     r_waddr;
  logic [PAGE_W-1:0] r_wdata;
  logic [IW-1:0]     r_raddr;
  logic [PAGE_W-1:0] r_rdata;
  logic              q_we;
  logic [IW-1:0]     q_waddr;
  logic [PAGE_W-1:0] q_wdata;
  logic [PAGE_W-1:0] q_rdata;

  logic [CW1-1:0]    idx_nx1, idx_nx2, rfill_ext;
  logic              match;
  logic [ADDR_W-1:0] front;

  rpl_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (PAGE_W),
    .AW    (IW)
  ) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // Queue memory is read at the head continuously
  rpl_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (PAGE_W),
    .AW    (IW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (qhead_q),
    .rdata_o (q_rdata)
  );

  assign idx_nx1   = CW1'(idx_q) + CW1'(1);
  assign idx_nx2   = CW1'(idx_q) + CW1'(2);
  assign rfill_ext = CW1'(rfill_q);
  assign match     = (r_rdata == page_q);
  assign front     = (qfill_q != '0) ? {q_rdata, {PAGE_SHIFT{1'b0}}} : '0;

  // Sequence one item through the memories
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    page_d   = page_q;
    pop_d    = pop_q;
    rfill_d  = rfill_q;
    qhead_d  = qhead_q;
    qfill_d  = qfill_q;
    valid_d  = 1'b0;
    pf_d     = pf_q;
    issued_d = issued_q;
    qcnt_d   = qcnt_q;
    rcnt_d   = rcnt_q;
    r_we     = 1'b0;
    r_waddr  = idx_q;
    r_wdata  = r_rdata;
    r_raddr  = idx_q;
    q_we     = 1'b0;
    q_waddr  = idx_q;
    q_wdata  = r_rdata;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          page_d = addr_i[ADDR_W-1:PAGE_SHIFT];
          pop_d  = 1'b0;
          idx_d  = '0;
          case (func_i)
            FUNC_RECORD: begin
              r_raddr = '0;
              state_d = (rfill_q == '0) ? ST_APPEND : ST_SCAN;
            end
            FUNC_GATHER: begin
              if (rfill_q == '0) begin
                qfill_d = '0;
                qhead_d = '0;
                state_d = ST_REPORT;
              end else begin
                r_raddr = IW'(rfill_q - CW'(1));
                state_d = ST_GATHER;
              end
            end
            FUNC_ISSUE: begin
              pop_d   = accepted_i;
              state_d = ST_REPORT;
            end
            default: begin
              state_d = ST_REPORT;
            end
          endcase
        end
      end

      // Compare one listed page per cycle, oldest first
      ST_SCAN: begin
        if (match) begin
          if (idx_nx1 < rfill_ext) begin
            r_raddr = IW'(idx_nx1);
            state_d = ST_SHIFT;
          end else begin
            rfill_d = rfill_q - CW'(1);
            state_d = ST_APPEND;
          end
        end else if (idx_nx1 < rfill_ext) begin
          r_raddr = IW'(idx_nx1);
          idx_d   = IW'(idx_nx1);
        end else if (rfill_q == CW'(LIST_DEPTH)) begin
          // Full and not present: drop the oldest page
          if (rfill_q > CW'(1)) begin
            r_raddr = IW'(1);
            idx_d   = '0;
            state_d = ST_SHIFT;
          end else begin
            rfill_d = rfill_q - CW'(1);
            state_d = ST_APPEND;
          end
        end else begin
          state_d = ST_APPEND;
        end
      end

      // Move entries down by one over the removed slot
      ST_SHIFT: begin
        r_we    = 1'b1;
        r_waddr = idx_q;
        r_wdata = r_rdata;
        if (idx_nx2 < rfill_ext) begin
          r_raddr = IW'(idx_nx2);
          idx_d   = IW'(idx_nx1);
        end else begin
          rfill_d = rfill_q - CW'(1);
          state_d = ST_APPEND;
        end
      end

      // Place the page at the newest end
      ST_APPEND: begin
        r_we    = 1'b1;
        r_waddr = IW'(rfill_q);
        r_wdata = page_q;
        rfill_d = rfill_q + CW'(1);
        state_d = ST_REPORT;
      end

      // Copy the list into the queue, newest first
      ST_GATHER: begin
        q_we    = 1'b1;
        q_waddr = idx_q;
        q_wdata = r_rdata;
        if (idx_nx1 < rfill_ext) begin
          r_raddr = IW'(rfill_ext - idx_nx1 - CW1'(1));
          idx_d   = IW'(idx_nx1);
        end else begin
          qfill_d = rfill_q;
          qhead_d = '0;
          rfill_d = '0;
          state_d = ST_SETTLE;
        end
      end

      // Let the queue head read see the new contents
      ST_SETTLE: begin
        state_d = ST_REPORT;
      end

      // Pop on an accepted issue and load the result
      ST_REPORT: begin
        valid_d = 1'b1;
        pf_d    = front;
        rcnt_d  = COUNT_W'(rfill_q);
        if (pop_q && (qfill_q != '0)) begin
          issued_d = 1'b1;
          qhead_d  = qhead_q + IW'(1);
          qfill_d  = qfill_q - CW'(1);
          qcnt_d   = COUNT_W'(qfill_q - CW'(1));
        end else begin
          issued_d = 1'b0;
          qcnt_d   = COUNT_W'(qfill_q);
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rfill_q <= '0;
      qhead_q <= '0;
      qfill_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rfill_q <= rfill_d;
      qhead_q <= qhead_d;
      qfill_q <= qfill_d;
      valid_q <= valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    page_q   <= page_d;
    pop_q    <= pop_d;
    pf_q     <= pf_d;
    issued_q <= issued_d;
    qcnt_q   <= qcnt_d;
    rcnt_q   <= rcnt_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign valid_o        = valid_q;
  assign pf_addr_o      = pf_q;
  assign issued_o       = issued_q;
  assign queue_count_o  = qcnt_q;
  assign recent_count_o = rcnt_q;

endmodule

`default_nettype wire

>>> hdl/rpl_ram.sv
`default_nettype none

module rpl_ram #(
  parameter int DEPTH = rpl_pkg::LIST_DEPTH_DEF,
  parameter int WIDTH = rpl_pkg::PAGE_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  import rpl_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read every cycle, data in the next cycle (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
